// ===== rtl/rotary_dial_pulse_decoder_defines.svh =====
// Assertion macros used by the checker file of the dial decoder.
`ifndef ROTARY_DIAL_PULSE_DECODER_DEFINES_SVH
`define ROTARY_DIAL_PULSE_DECODER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define RDPD_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define RDPD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/rdpd_pkg.sv =====
`default_nettype none

package rdpd_pkg;

    // Default width of the debounce timebase and the time stamps.
    localparam int TIMEBASE_BITS_DEF = 8;

    // Field widths.
    localparam int CFG_W   = 8;
    localparam int KEY_W   = 6;
    localparam int COUNT_W = 8;

    // Configuration reset value and key code constants.
    localparam logic [CFG_W-1:0]   DEBOUNCE_RESET = 8'd2;
    localparam logic [KEY_W-1:0]   KEY_BASE       = 6'd29;
    localparam logic [KEY_W-1:0]   KEY_RELEASE    = 6'd0;
    localparam logic [COUNT_W-1:0] COUNT_LIMIT    = 8'd11;
    localparam logic [COUNT_W-1:0] COUNT_MAX      = 8'd255;

    // Contact index in the per-contact arrays.
    localparam int CONTACT_TICK = 0;
    localparam int CONTACT_DIAL = 1;
    localparam int NUM_CONTACTS = 2;

    // Results one sample leaves in the output stage.
    typedef struct packed {
        logic              press;
        logic              release_key;
        logic [KEY_W-1:0]  key;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/rdpd_in_if.sv =====
`default_nettype none

// Switch sample channel.
interface rdpd_in_if import rdpd_pkg::*; ();
    logic valid;
    logic ready;
    logic tick_switch;
    logic dial_switch;
    logic time_tick;

    modport source (output valid, output tick_switch, output dial_switch,
                    output time_tick, input ready);
    modport sink   (input valid, input tick_switch, input dial_switch,
                    input time_tick, output ready);
endinterface

`default_nettype wire

// ===== rtl/rdpd_out_if.sv =====
`default_nettype none

// Key code channel.
interface rdpd_out_if import rdpd_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [KEY_W-1:0] key_code;
    logic             last_of_run;

    modport source (output valid, output key_code, output last_of_run, input ready);
    modport sink   (input valid, input key_code, input last_of_run, output ready);
endinterface

`default_nettype wire

// ===== rtl/rotary_dial_pulse_decoder.sv =====
// Rotary dial pulse decoder. Each input word is one sample of the pulse and off-normal
// contacts plus a timebase advance flag; both contacts are debounced against a
// TIMEBASE_BITS wide tick counter and the debounce_ticks register. A sample is folded
// into the state in the cycle it is accepted, and its results go to a one-entry output
// stage holding an optional digit key (30 to 39) followed by a release (0). A new sample
// is accepted while the output stage is empty or handing over its last word; a sample
// that completes a digit occupies the stage for two output words, so the next sample
// waits until its release is taken, limited by the single output port. Write
// debounce_ticks only while no words are pending.
`default_nettype none

module rotary_dial_pulse_decoder import rdpd_pkg::*; #(
    parameter int TIMEBASE_BITS = TIMEBASE_BITS_DEF
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_cfg_we,
    input  wire  [CFG_W-1:0] i_cfg_data,
    rdpd_in_if.sink          i_in,
    rdpd_out_if.source       o_out
);

    localparam int CMP_W = (TIMEBASE_BITS > CFG_W) ? TIMEBASE_BITS : CFG_W;

    // Registers.
    logic [CFG_W-1:0]         r_debounce;
    logic [TIMEBASE_BITS-1:0] r_time;
    logic [COUNT_W-1:0]       r_count;
    logic [NUM_CONTACTS-1:0]  r_raw_prev;
    logic [NUM_CONTACTS-1:0]  r_stable;
    logic [NUM_CONTACTS-1:0]  r_bouncing;
    logic [TIMEBASE_BITS-1:0] r_stamp [NUM_CONTACTS];
    t_result                  r_res;

    // Next values.
    logic [TIMEBASE_BITS-1:0] n_time;
    logic [COUNT_W-1:0]       n_count;
    logic [NUM_CONTACTS-1:0]  n_stable;
    logic [NUM_CONTACTS-1:0]  n_bouncing;
    logic [TIMEBASE_BITS-1:0] n_stamp [NUM_CONTACTS];
    t_result                  n_res;

    logic [NUM_CONTACTS-1:0]  raw;
    logic [NUM_CONTACTS-1:0]  toggled;
    logic [TIMEBASE_BITS-1:0] elapsed [NUM_CONTACTS];
    logic [COUNT_W-1:0]       count_bumped;
    logic                     in_fire;
    logic                     out_fire;

    assign raw[CONTACT_TICK] = i_in.tick_switch;
    assign raw[CONTACT_DIAL] = i_in.dial_switch;

    // The stage takes a sample when empty or when its last word leaves now.
    assign i_in.ready = !r_res.release_key || (!r_res.press && o_out.ready);
    assign in_fire    = i_in.valid && i_in.ready;
    assign out_fire   = o_out.valid && o_out.ready;

    // Debounce both contacts against the timebase.
    always_comb begin
        for (int c = 0; c < NUM_CONTACTS; c++) begin
            elapsed[c]    = r_time - r_stamp[c];
            n_stable[c]   = r_stable[c];
            n_bouncing[c] = r_bouncing[c];
            n_stamp[c]    = r_stamp[c];
            toggled[c]    = 1'b0;
            if (raw[c] != r_raw_prev[c]) begin
                n_bouncing[c] = 1'b1;
                n_stamp[c]    = r_time;
            end else if (r_bouncing[c] &&
                         (CMP_W'(elapsed[c]) >= CMP_W'(r_debounce))) begin
                n_bouncing[c] = 1'b0;
                if (raw[c] != r_stable[c]) begin
                    n_stable[c] = raw[c];
                    toggled[c]  = 1'b1;
                end
            end
        end
    end

    // Pulse counting and key generation.
    always_comb begin
        count_bumped = r_count;
        if (toggled[CONTACT_TICK] && n_stable[CONTACT_TICK] && (r_count != COUNT_MAX)) begin
            count_bumped = r_count + COUNT_W'(1);
        end
        n_res.press       = toggled[CONTACT_DIAL] && n_stable[CONTACT_DIAL] &&
                            (count_bumped != '0) && (count_bumped < COUNT_LIMIT);
        n_res.release_key = toggled[CONTACT_DIAL];
        n_res.key         = KEY_BASE + KEY_W'(count_bumped);
        n_count           = toggled[CONTACT_DIAL] ? '0 : count_bumped;
        n_time            = i_in.time_tick ? r_time + TIMEBASE_BITS'(1) : r_time;
    end

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce <= DEBOUNCE_RESET;
        end else if (i_cfg_we) begin
            r_debounce <= i_cfg_data;
        end
    end

    // Decoder state, updated once per accepted sample.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time     <= '0;
            r_count    <= '0;
            r_raw_prev <= '1;
            r_stable   <= '1;
            r_bouncing <= '0;
            for (int c = 0; c < NUM_CONTACTS; c++) begin
                r_stamp[c] <= '0;
            end
        end else if (in_fire) begin
            r_time     <= n_time;
            r_count    <= n_count;
            r_raw_prev <= raw;
            r_stable   <= n_stable;
            r_bouncing <= n_bouncing;
            for (int c = 0; c < NUM_CONTACTS; c++) begin
                r_stamp[c] <= n_stamp[c];
            end
        end
    end

    // Output stage: press goes out first, then the release.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res.press       <= 1'b0;
            r_res.release_key <= 1'b0;
        end else if (in_fire) begin
            r_res <= n_res;
        end else if (out_fire) begin
            if (r_res.press) begin
                r_res.press <= 1'b0;
            end else begin
                r_res.release_key <= 1'b0;
            end
        end
    end

    assign o_out.valid       = r_res.release_key;
    assign o_out.key_code    = r_res.press ? r_res.key : KEY_RELEASE;
    assign o_out.last_of_run = !r_res.press;

endmodule

`default_nettype wire

// ===== rtl/rdpd_checker.sv =====
`default_nettype none
`include "rotary_dial_pulse_decoder_defines.svh"

module rdpd_checker import rdpd_pkg::*; (
    input wire             i_clk,
    input wire             i_rst_n,
    input wire             i_in_ready,
    input wire             i_out_valid,
    input wire             i_out_ready,
    input wire [KEY_W-1:0] i_key_code,
    input wire             i_last_of_run
);

    // A release word always closes the run, a digit word never does.
    `RDPD_ASSERT_NOW(a_last_matches_release, i_clk, i_rst_n, i_out_valid, ((i_key_code == KEY_RELEASE) == i_last_of_run), "last_of_run does not match key code")

    // Digit words only carry codes for digits 1 to 9 and 0.
    `RDPD_ASSERT_NOW(a_digit_range, i_clk, i_rst_n, i_out_valid && (i_key_code != KEY_RELEASE), (i_key_code > KEY_BASE) && (i_key_code <= KEY_BASE + KEY_W'(10)), "digit key code out of range")

    // A digit word that is taken is followed by its release.
    `RDPD_ASSERT_NEXT(a_release_follows, i_clk, i_rst_n, i_out_valid && i_out_ready && !i_last_of_run, i_out_valid && (i_key_code == KEY_RELEASE), "digit not followed by release")

    // No sample is taken while a digit still waits in front of its release.
    `RDPD_ASSERT_NOW(a_hold_on_digit, i_clk, i_rst_n, i_out_valid && !i_last_of_run, !i_in_ready, "sample taken over a pending digit")

    // With nothing pending the decoder always takes samples.
    `RDPD_ASSERT_NOW(a_ready_when_empty, i_clk, i_rst_n, !i_out_valid, i_in_ready, "not ready with empty output")

endmodule

bind rotary_dial_pulse_decoder rdpd_checker u_rdpd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_key_code    (o_out.key_code),
    .i_last_of_run (o_out.last_of_run)
);

`default_nettype wire
